>>> rtl/gcra_pkg.sv
package gcra_pkg;

    // Table geometry.
    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int COUNT_W  = SLOT_W + 1;

    // Field widths.
    localparam int ID_W     = 7;
    localparam int BYTES_W  = 32;
    localparam int SIZE_W   = 48;
    localparam int OBJS_W   = 32;
    localparam int KIND_W   = 3;
    localparam int MULT_W   = 11;
    localparam int PROD_W   = BYTES_W + MULT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Saturation limits.
    localparam logic [SIZE_W-1:0] SAT_SIZE = {SIZE_W{1'b1}};
    localparam logic [OBJS_W-1:0] SAT_OBJS = {OBJS_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_YOUNG_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_MULT    = 2'd1;

    // Configuration reset values.
    localparam logic [BYTES_W-1:0] YOUNG_BYTES_RST = 32'd1048576;
    localparam logic [MULT_W-1:0]  OLD_MULT_RST    = 11'd8;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_REASSIGN = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // Region kinds that own a current region.
    localparam logic [KIND_W-1:0] KIND_EDEN     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SURVIVOR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OLD      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CURRENT_LIMIT = 3'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [KIND_W-1:0]  region_kind;
        logic [ID_W-1:0]    region_id;
        logic [BYTES_W-1:0] object_bytes;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   assigned_region;
        logic [1:0]        status;
        logic [SIZE_W-1:0] used_bytes_after;
        logic [OBJS_W-1:0] live_objects_after;
    } t_rsp;

    typedef struct packed {
        logic [BYTES_W-1:0] young_bytes;
        logic [MULT_W-1:0]  old_mult;
    } t_cfg;

    // One region record as held in the slot memory.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] cap;
        logic [SIZE_W-1:0] used;
        logic [SIZE_W-1:0] live;
        logic [OBJS_W-1:0] objs;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

endpackage

>>> rtl/gcra_req_if.sv
interface gcra_req_if;
    logic            valid;
    logic            ready;
    gcra_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gcra_rsp_if.sv
interface gcra_rsp_if;
    logic            valid;
    logic            ready;
    gcra_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gcra_ram.sv
module gcra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gcra_cfg.sv
module gcra_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gcra_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcra_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output gcra_pkg::t_cfg                    o_cfg
);

    gcra_pkg::t_cfg r_cfg;

    // Register file; writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.young_bytes <= gcra_pkg::YOUNG_BYTES_RST;
            r_cfg.old_mult    <= gcra_pkg::OLD_MULT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gcra_pkg::CFG_YOUNG_BYTES: r_cfg.young_bytes <= i_cfg_data;
                gcra_pkg::CFG_OLD_MULT:
                    r_cfg.old_mult <= i_cfg_data[gcra_pkg::MULT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/gc_region_bump_allocator.sv
// Channel   Dir  Payload                                              Transfer
// i_req     in   opcode, region_kind, region_id, object_bytes         valid & ready
// o_rsp     out  assigned_region, status, used_bytes_after, live_obj. valid & ready
// i_cfg_*   in   register index and data                              i_cfg_we
//
// One item at a time, from the transfer on i_req to the load of the output register.
// An unknown or zero release and the unused code go straight to the result, a known
// release reads and writes back its slot, a bump of the current region checks it and
// bumps it, and otherwise the region slots are scanned in order, at most 64 of them.
// The slot scan through the single read port of the slot memory is the longest path.
// Reset is synchronous; the slot memory is not cleared, a slot is read only
// after its region has been created. A result waiting in the output register
// does not block the next transfer on i_req; it stalls the sequencer only at its end.
module gc_region_bump_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gcra_req_if.sink                          i_req,
    gcra_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [gcra_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcra_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_NEED, S_REL_RD, S_REL_WR, S_ALC, S_CUR_CK, S_SCAN, S_BUMP, S_DONE
    } t_state;

    gcra_pkg::t_cfg  w_cfg;
    gcra_pkg::t_slot w_rdata;
    gcra_pkg::t_slot w_wdata;
    logic            w_we;
    logic [gcra_pkg::SLOT_W-1:0] w_waddr;
    logic [gcra_pkg::SLOT_W-1:0] w_raddr;

    t_state r_state;
    logic [1:0]                      r_op;
    logic [gcra_pkg::KIND_W-1:0]     r_kind;
    logic [gcra_pkg::ID_W-1:0]       r_id;
    logic [gcra_pkg::BYTES_W-1:0]    r_req;
    logic [gcra_pkg::BYTES_W-1:0]    r_young;
    logic [gcra_pkg::PROD_W-1:0]     r_prod;
    logic [gcra_pkg::SIZE_W-1:0]     r_need;
    logic [gcra_pkg::COUNT_W-1:0]    r_in_use;
    logic [gcra_pkg::ID_W-1:0]       r_cur [3];
    logic [gcra_pkg::COUNT_W-1:0]    r_idx;
    logic                            r_chk_v;
    logic [gcra_pkg::SLOT_W-1:0]     r_chk_idx;
    logic [gcra_pkg::SLOT_W-1:0]     r_slot;
    gcra_pkg::t_slot                 r_rec;
    gcra_pkg::t_rsp                  r_res;
    gcra_pkg::t_rsp                  r_out;
    logic                            r_out_v;

    gcra_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    gcra_ram #(
        .WIDTH (gcra_pkg::SLOT_BITS),
        .DEPTH (gcra_pkg::SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Helper terms of the current item.
    logic                            w_cur_kind;
    logic [gcra_pkg::ID_W-1:0]       w_cur;
    logic                            w_id_known;
    logic [gcra_pkg::BYTES_W-1:0]    w_young;
    logic [gcra_pkg::SIZE_W-1:0]     w_cap;
    logic [gcra_pkg::SIZE_W:0]       w_fit_sum;
    logic                            w_scan_hit;
    logic [gcra_pkg::SIZE_W-1:0]     w_rel_live;
    logic [gcra_pkg::OBJS_W-1:0]     w_rel_objs;
    logic [gcra_pkg::SIZE_W:0]       w_used_sum;
    logic [gcra_pkg::SIZE_W:0]       w_live_sum;
    logic [gcra_pkg::SIZE_W-1:0]     w_used_new;
    logic [gcra_pkg::SIZE_W-1:0]     w_live_new;
    logic [gcra_pkg::OBJS_W-1:0]     w_objs_new;
    logic [gcra_pkg::SIZE_W-1:0]     w_req48;

    assign w_req48    = {{(gcra_pkg::SIZE_W-gcra_pkg::BYTES_W){1'b0}}, r_req};
    assign w_cur_kind = r_kind < gcra_pkg::KIND_CURRENT_LIMIT;
    assign w_cur      = w_cur_kind ? r_cur[r_kind[1:0]] : '0;
    assign w_id_known = (r_id != '0) &&
                        ({1'b0, r_id} <= {{(gcra_pkg::ID_W+1-gcra_pkg::COUNT_W){1'b0}}, r_in_use});
    assign w_young    = (w_cfg.young_bytes == '0) ? gcra_pkg::BYTES_W'(1) : w_cfg.young_bytes;

    // Region capacity by kind before taking the request into account; other kinds take the request size.
    always_comb begin
        case (r_kind)
            gcra_pkg::KIND_EDEN, gcra_pkg::KIND_SURVIVOR:
                w_cap = {{(gcra_pkg::SIZE_W-gcra_pkg::BYTES_W){1'b0}}, r_young};
            gcra_pkg::KIND_OLD:
                w_cap = {{(gcra_pkg::SIZE_W-gcra_pkg::PROD_W){1'b0}}, r_prod};
            default:
                w_cap = w_req48;
        endcase
    end

    // Fit check for the current region and match check for the scan.
    assign w_fit_sum  = {1'b0, w_rdata.used} + {1'b0, w_req48};
    assign w_scan_hit = r_chk_v && (w_rdata.kind == r_kind) && (w_rdata.objs == '0) &&
                        (w_rdata.cap >= r_need);

    // Release arithmetic on the record read back.
    assign w_rel_live = (w_rdata.live <= w_req48) ? '0 : w_rdata.live - w_req48;
    assign w_rel_objs = (w_rdata.objs != '0) ? w_rdata.objs - 1'b1 : '0;

    // Bump arithmetic with saturation.
    assign w_used_sum = {1'b0, r_rec.used} + {1'b0, w_req48};
    assign w_live_sum = {1'b0, r_rec.live} + {1'b0, w_req48};
    assign w_used_new = w_used_sum[gcra_pkg::SIZE_W] ? gcra_pkg::SAT_SIZE
                                                     : w_used_sum[gcra_pkg::SIZE_W-1:0];
    assign w_live_new = w_live_sum[gcra_pkg::SIZE_W] ? gcra_pkg::SAT_SIZE
                                                     : w_live_sum[gcra_pkg::SIZE_W-1:0];
    assign w_objs_new = (r_rec.objs == gcra_pkg::SAT_OBJS) ? r_rec.objs : r_rec.objs + 1'b1;

    // Memory read address and write port.
    always_comb begin
        w_raddr = r_idx[gcra_pkg::SLOT_W-1:0];
        w_we    = 1'b0;
        w_waddr = r_slot;
        w_wdata = r_rec;
        unique case (r_state)
            S_REL_RD: w_raddr = gcra_pkg::SLOT_W'(r_id - 1'b1);
            S_ALC:    w_raddr = gcra_pkg::SLOT_W'(w_cur - 1'b1);
            S_REL_WR: begin
                w_we          = 1'b1;
                w_waddr       = gcra_pkg::SLOT_W'(r_id - 1'b1);
                w_wdata       = w_rdata;
                w_wdata.objs  = w_rel_objs;
                w_wdata.live  = (w_rel_objs == '0) ? '0 : w_rel_live;
                w_wdata.used  = (w_rel_objs == '0) ? '0 : w_rdata.used;
            end
            S_BUMP: begin
                w_we         = 1'b1;
                w_wdata.used = w_used_new;
                w_wdata.live = w_live_new;
                w_wdata.objs = w_objs_new;
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_v;
    assign o_rsp.data  = r_out;

    // Sequencer, table counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_out_v  <= 1'b0;
            r_in_use <= '0;
            r_cur[0] <= '0;
            r_cur[1] <= '0;
            r_cur[2] <= '0;
            r_chk_v  <= 1'b0;
        end else begin
            // The output register fills from the sequencer and empties on a transfer.
            if (r_state == S_DONE && (!r_out_v || o_rsp.ready)) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.data.opcode;
                        r_kind  <= i_req.data.region_kind;
                        r_id    <= i_req.data.region_id;
                        r_req   <= (i_req.data.object_bytes == '0) ?
                                   gcra_pkg::BYTES_W'(1) : i_req.data.object_bytes;
                        r_young <= w_young;
                        r_prod  <= w_young * ((w_cfg.old_mult == '0) ?
                                   gcra_pkg::MULT_W'(1) : w_cfg.old_mult);
                        r_state <= S_NEED;
                    end
                end
                S_NEED: begin
                    r_need <= (w_cap > w_req48) ? w_cap : w_req48;
                    // Only a plain release of a nonzero unknown id reports ST_UNKNOWN.
                    r_res  <= {{gcra_pkg::ID_W{1'b0}},
                               (r_op == gcra_pkg::OP_RELEASE && !w_id_known && r_id != '0) ?
                               gcra_pkg::ST_UNKNOWN : gcra_pkg::ST_OK,
                               {gcra_pkg::SIZE_W{1'b0}}, {gcra_pkg::OBJS_W{1'b0}}};
                    unique case (r_op)
                        gcra_pkg::OP_ALLOC: r_state <= S_ALC;
                        gcra_pkg::OP_RELEASE: r_state <= w_id_known ? S_REL_RD : S_DONE;
                        gcra_pkg::OP_REASSIGN: r_state <= w_id_known ? S_REL_RD : S_ALC;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_REL_RD: r_state <= S_REL_WR;
                S_REL_WR: begin
                    // An emptied region stops being current for its kind.
                    if (w_rel_objs == '0 && w_rdata.kind < gcra_pkg::KIND_CURRENT_LIMIT &&
                        r_cur[w_rdata.kind[1:0]] == r_id) begin
                        r_cur[w_rdata.kind[1:0]] <= '0;
                    end
                    r_res   <= {{gcra_pkg::ID_W{1'b0}}, gcra_pkg::ST_OK,
                                (w_rel_objs == '0) ? {gcra_pkg::SIZE_W{1'b0}} : w_rdata.used,
                                w_rel_objs};
                    r_state <= (r_op == gcra_pkg::OP_RELEASE) ? S_DONE : S_ALC;
                end
                S_ALC: begin
                    r_idx   <= '0;
                    r_chk_v <= 1'b0;
                    if (w_cur != '0 &&
                        {1'b0, w_cur} <= {{(gcra_pkg::ID_W+1-gcra_pkg::COUNT_W){1'b0}}, r_in_use}) begin
                        r_state <= S_CUR_CK;
                    end else begin
                        if (w_cur_kind) begin
                            r_cur[r_kind[1:0]] <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_CUR_CK: begin
                    if (w_rdata.kind == r_kind &&
                        w_fit_sum <= {1'b0, w_rdata.cap}) begin
                        r_slot  <= gcra_pkg::SLOT_W'(w_cur - 1'b1);
                        r_rec   <= w_rdata;
                        r_state <= S_BUMP;
                    end else begin
                        r_cur[r_kind[1:0]] <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // One slot read issued per cycle; the compare checks the registered read data of slot r_chk_idx.
                    if (w_scan_hit) begin
                        r_slot     <= r_chk_idx;
                        r_rec      <= {r_kind, (w_rdata.cap > r_need) ? w_rdata.cap : r_need,
                                       {gcra_pkg::SIZE_W{1'b0}}, {gcra_pkg::SIZE_W{1'b0}},
                                       {gcra_pkg::OBJS_W{1'b0}}};
                        r_chk_v    <= 1'b0;
                        r_state    <= S_BUMP;
                    end else if (r_idx < r_in_use) begin
                        r_chk_v   <= 1'b1;
                        r_chk_idx <= r_idx[gcra_pkg::SLOT_W-1:0];
                        r_idx     <= r_idx + 1'b1;
                    end else begin
                        r_chk_v <= 1'b0;
                        if (r_in_use >= gcra_pkg::COUNT_W'(gcra_pkg::SLOTS)) begin
                            r_res        <= {{gcra_pkg::ID_W{1'b0}}, gcra_pkg::ST_FULL,
                                             {gcra_pkg::SIZE_W{1'b0}}, {gcra_pkg::OBJS_W{1'b0}}};
                            r_state      <= S_DONE;
                        end else begin
                            r_slot     <= r_in_use[gcra_pkg::SLOT_W-1:0];
                            r_in_use   <= r_in_use + 1'b1;
                            r_rec      <= {r_kind, r_need, {gcra_pkg::SIZE_W{1'b0}},
                                           {gcra_pkg::SIZE_W{1'b0}}, {gcra_pkg::OBJS_W{1'b0}}};
                            r_state    <= S_BUMP;
                        end
                    end
                end
                S_BUMP: begin
                    if (w_cur_kind) begin
                        r_cur[r_kind[1:0]] <= gcra_pkg::ID_W'({1'b0, r_slot} + 1'b1);
                    end
                    r_res   <= {gcra_pkg::ID_W'({1'b0, r_slot} + 1'b1), gcra_pkg::ST_OK,
                                w_used_new, w_objs_new};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_v || o_rsp.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> test/gc_region_bump_allocator_tb.sv
module gc_region_bump_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package does not name.
    localparam logic [1:0]                  OP_UNUSED      = 2'd3;
    localparam logic [gcra_pkg::KIND_W-1:0] KIND_PINNED    = 3'd3;
    localparam logic [gcra_pkg::KIND_W-1:0] KIND_LARGE     = 3'd4;
    localparam logic [gcra_pkg::KIND_W-1:0] KIND_PERMANENT = 3'd5;
    localparam logic [gcra_pkg::KIND_W-1:0] KIND_SPARE6    = 3'd6;
    localparam logic [gcra_pkg::KIND_W-1:0] KIND_SPARE7    = 3'd7;
    localparam logic [63:0]       SIZE_MAX       = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0]       OBJS_MAX       = 64'hFFFF_FFFF;
    localparam int                WATCHDOG_LIMIT = 20000;
    localparam int                DRAIN_CYCLES   = 100;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [gcra_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gcra_pkg::CFG_DATA_W-1:0] i_cfg_data;

    gcra_req_if req_if ();
    gcra_rsp_if rsp_if ();

    gc_region_bump_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the region table and the configuration.
    logic [gcra_pkg::KIND_W-1:0] tbl_kind [gcra_pkg::SLOTS];
    logic [63:0]       tbl_cap  [gcra_pkg::SLOTS];
    logic [63:0]       tbl_used [gcra_pkg::SLOTS];
    logic [63:0]       tbl_live [gcra_pkg::SLOTS];
    logic [63:0]       tbl_objs [gcra_pkg::SLOTS];
    int unsigned       regions_made;
    int unsigned       cur_id [3];
    logic [gcra_pkg::BYTES_W-1:0] cfg_young;
    logic [gcra_pkg::MULT_W-1:0]  cfg_mult;

    gcra_pkg::t_rsp expected_rsp [$];
    int             error_count;
    int             idle_cycles;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;

    always #5 i_clk = ~i_clk;

    // Capacity a new or reused region of this kind must offer.
    function automatic logic [63:0] region_need(logic [gcra_pkg::KIND_W-1:0] kind,
                                                logic [63:0] req);
        logic [63:0] young;
        logic [63:0] cap;
        young = (cfg_young == 0) ? 64'd1 : 64'(cfg_young);
        if (kind == gcra_pkg::KIND_EDEN || kind == gcra_pkg::KIND_SURVIVOR) begin
            cap = young;
        end else if (kind == gcra_pkg::KIND_OLD) begin
            cap = young * ((cfg_mult == 0) ? 64'd1 : 64'(cfg_mult));
        end else begin
            return req;
        end
        return (cap > req) ? cap : req;
    endfunction

    function automatic logic [63:0] sat_size(logic [63:0] a, logic [63:0] b);
        return (a + b > SIZE_MAX) ? SIZE_MAX : a + b;
    endfunction

    // Drops one object from a region; an emptied region is cleared.
    function automatic bit release_object(int unsigned id, logic [63:0] req,
                                          inout gcra_pkg::t_rsp r);
        int unsigned s;
        if (id == 0 || id > regions_made) return 0;
        s = id - 1;
        tbl_live[s] = (tbl_live[s] <= req) ? 64'd0 : tbl_live[s] - req;
        if (tbl_objs[s] > 0) tbl_objs[s]--;
        if (tbl_objs[s] == 0) begin
            tbl_used[s] = 0;
            tbl_live[s] = 0;
            if (tbl_kind[s] < gcra_pkg::KIND_CURRENT_LIMIT && cur_id[tbl_kind[s]] == id)
                cur_id[tbl_kind[s]] = 0;
        end
        r.used_bytes_after   = tbl_used[s][gcra_pkg::SIZE_W-1:0];
        r.live_objects_after = tbl_objs[s][gcra_pkg::OBJS_W-1:0];
        return 1;
    endfunction

    // Bumps the current region, else reuses an empty one, else creates one, else reports full.
    function automatic void bump_allocate(logic [gcra_pkg::KIND_W-1:0] kind, logic [63:0] req,
                                          inout gcra_pkg::t_rsp r);
        logic [63:0] need;
        int          s;
        int unsigned c;
        need = region_need(kind, req);
        s = -1;
        if (kind < gcra_pkg::KIND_CURRENT_LIMIT && cur_id[kind] != 0) begin
            c = cur_id[kind];
            if (c <= regions_made && tbl_kind[c-1] == kind
                    && tbl_used[c-1] + req <= tbl_cap[c-1]) begin
                s = c - 1;
            end else begin
                cur_id[kind] = 0;
            end
        end
        if (s < 0) begin
            for (int i = 0; i < int'(regions_made); i++) begin
                if (s < 0 && tbl_kind[i] == kind && tbl_objs[i] == 0 && tbl_cap[i] >= need)
                    s = i;
            end
            if (s < 0) begin
                if (regions_made >= gcra_pkg::SLOTS) begin
                    r = '0;
                    r.status = gcra_pkg::ST_FULL;
                    return;
                end
                s = regions_made;
                regions_made++;
                tbl_cap[s] = need;
            end
            tbl_kind[s] = kind;
            if (tbl_cap[s] < need) tbl_cap[s] = need;
            tbl_used[s] = 0;
            tbl_live[s] = 0;
            tbl_objs[s] = 0;
        end
        tbl_used[s] = sat_size(tbl_used[s], req);
        tbl_live[s] = sat_size(tbl_live[s], req);
        if (tbl_objs[s] < OBJS_MAX) tbl_objs[s]++;
        if (kind < gcra_pkg::KIND_CURRENT_LIMIT) cur_id[kind] = s + 1;
        r.assigned_region    = gcra_pkg::ID_W'(s + 1);
        r.status             = gcra_pkg::ST_OK;
        r.used_bytes_after   = tbl_used[s][gcra_pkg::SIZE_W-1:0];
        r.live_objects_after = tbl_objs[s][gcra_pkg::OBJS_W-1:0];
    endfunction

    // Expected result of one request, updating the shadow table.
    function automatic gcra_pkg::t_rsp allocator_result(gcra_pkg::t_req q);
        gcra_pkg::t_rsp r;
        logic [63:0]    req;
        bit             known;
        r = '0;
        req = (q.object_bytes == 0) ? 64'd1 : 64'(q.object_bytes);
        case (q.opcode)
            gcra_pkg::OP_ALLOC: begin
                bump_allocate(q.region_kind, req, r);
            end
            gcra_pkg::OP_RELEASE: begin
                if (q.region_id != 0) begin
                    known = release_object(q.region_id, req, r);
                    if (!known) r.status = gcra_pkg::ST_UNKNOWN;
                end
            end
            gcra_pkg::OP_REASSIGN: begin
                known = release_object(q.region_id, req, r);
                bump_allocate(q.region_kind, req, r);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Result checker: every transfer on the response channel meets the oldest expectation.
    always @(posedge i_clk) begin
        gcra_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(rsp_if.data.status), 64'd0);
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_if.data.assigned_region !== want.assigned_region)
                    report_mismatch("assigned_region", 64'(rsp_if.data.assigned_region),
                                    64'(want.assigned_region));
                if (rsp_if.data.status !== want.status)
                    report_mismatch("status", 64'(rsp_if.data.status), 64'(want.status));
                if (rsp_if.data.used_bytes_after !== want.used_bytes_after)
                    report_mismatch("used_bytes_after", 64'(rsp_if.data.used_bytes_after),
                                    64'(want.used_bytes_after));
                if (rsp_if.data.live_objects_after !== want.live_objects_after)
                    report_mismatch("live_objects_after", 64'(rsp_if.data.live_objects_after),
                                    64'(want.live_objects_after));
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("FAIL gc_region_bump_allocator");
            $finish;
        end
    end

    // Sends one request and records its expected result at the transfer.
    task automatic send_request(logic [1:0] op, logic [gcra_pkg::KIND_W-1:0] kind,
                                logic [gcra_pkg::ID_W-1:0] id,
                                logic [gcra_pkg::BYTES_W-1:0] nbytes);
        gcra_pkg::t_req q;
        q.opcode       = op;
        q.region_kind  = kind;
        q.region_id    = id;
        q.object_bytes = nbytes;
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_rsp.push_back(allocator_result(q));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only called while nothing is in flight.
    task automatic write_register(logic [gcra_pkg::CFG_IDX_W-1:0] idx,
                                  logic [gcra_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == gcra_pkg::CFG_YOUNG_BYTES) cfg_young = value;
        else if (idx == gcra_pkg::CFG_OLD_MULT) cfg_mult = value[gcra_pkg::MULT_W-1:0];
    endtask

    task automatic set_config(logic [gcra_pkg::BYTES_W-1:0] young,
                              logic [gcra_pkg::MULT_W-1:0] mult);
        wait_drained();
        write_register(gcra_pkg::CFG_YOUNG_BYTES, young);
        write_register(gcra_pkg::CFG_OLD_MULT, gcra_pkg::CFG_DATA_W'(mult));
    endtask

    // Field extremes, every operation and the special cases.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(gcra_pkg::OP_RELEASE, gcra_pkg::KIND_EDEN, 7'd0, 32'd5);
        send_request(gcra_pkg::OP_RELEASE, gcra_pkg::KIND_EDEN, 7'd5, 32'd5);
        send_request(gcra_pkg::OP_RELEASE, gcra_pkg::KIND_EDEN, 7'h7F, 32'd5);
        send_request(OP_UNUSED, KIND_SPARE7, 7'h7F, 32'hFFFF_FFFF);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_EDEN, 7'd0, 32'd0);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_EDEN, 7'd0, 32'd100);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_SURVIVOR, 7'd0, 32'hFFFF_FFFF);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_OLD, 7'd0, 32'd4096);
        send_request(gcra_pkg::OP_ALLOC, KIND_PINNED, 7'd0, 32'd64);
        send_request(gcra_pkg::OP_ALLOC, KIND_LARGE, 7'd0, 32'hFFFF_FFFF);
        send_request(gcra_pkg::OP_ALLOC, KIND_PERMANENT, 7'd0, 32'd1);
        send_request(gcra_pkg::OP_ALLOC, KIND_SPARE6, 7'd0, 32'd10);
        send_request(gcra_pkg::OP_ALLOC, KIND_SPARE7, 7'd0, 32'd10);
        send_request(gcra_pkg::OP_RELEASE, gcra_pkg::KIND_EDEN, 7'd1, 32'd50);
        send_request(gcra_pkg::OP_RELEASE, gcra_pkg::KIND_EDEN, 7'd1, 32'd50);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_EDEN, 7'd0, 32'd8);
        send_request(gcra_pkg::OP_REASSIGN, gcra_pkg::KIND_OLD, 7'd0, 32'd16);
        send_request(gcra_pkg::OP_REASSIGN, gcra_pkg::KIND_SURVIVOR, 7'h7F, 32'd16);
        send_request(gcra_pkg::OP_REASSIGN, KIND_PINNED, 7'd5, 32'd64);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_EDEN, 7'd0, 32'd1048576);
        set_config(32'd0, 11'd0);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_OLD, 7'd0, 32'd0);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_OLD, 7'd0, 32'd0);
        set_config(32'hFFFF_FFFF, 11'h7FF);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_OLD, 7'd0, 32'hFFFF_FFFF);
        send_request(gcra_pkg::OP_ALLOC, gcra_pkg::KIND_EDEN, 7'd0, 32'hFFFF_FFFF);
    endtask

    // Random traffic, mostly on regions that exist so that reuse and bumping happen.
    task automatic test_random(int count, int unsigned idle_pct, int unsigned stall_pct,
                               bit hold_off);
        int unsigned                  pick;
        logic [1:0]                   op;
        logic [gcra_pkg::KIND_W-1:0]  kind;
        logic [gcra_pkg::ID_W-1:0]    id;
        logic [gcra_pkg::BYTES_W-1:0] nbytes;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = (pick < 45) ? gcra_pkg::OP_ALLOC : (pick < 75) ? gcra_pkg::OP_RELEASE :
                 (pick < 96) ? gcra_pkg::OP_REASSIGN : OP_UNUSED;
            kind = ($urandom_range(9) == 0) ? gcra_pkg::KIND_W'($urandom_range(7))
                                            : gcra_pkg::KIND_W'($urandom_range(5));
            pick = $urandom_range(9);
            if (pick < 7 && regions_made > 0)
                id = gcra_pkg::ID_W'($urandom_range(regions_made, 1));
            else if (pick < 8) id = '0;
            else id = gcra_pkg::ID_W'($urandom);
            pick = $urandom_range(9);
            if (pick < 5) nbytes = $urandom_range(4096);
            else if (pick < 6) nbytes = '0;
            else if (pick < 8) nbytes = $urandom_range(cfg_young + 64, cfg_young / 2);
            else nbytes = $urandom;
            send_request(op, kind, id, nbytes);
            if (hold_off && n == count / 2) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                while (expected_rsp.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        rsp_if.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        idle_cycles    = 0;
        regions_made   = 0;
        cur_id         = '{0, 0, 0};
        cfg_young      = gcra_pkg::YOUNG_BYTES_RST;
        cfg_mult       = gcra_pkg::OLD_MULT_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_config(32'd4096, 11'd1024);
        test_random(470, 0, 0, 0);
        set_config(32'd1, 11'd3);
        test_random(470, 86, 0, 1);
        set_config(32'd65536, 11'd0);
        test_random(470, 0, 86, 0);
        set_config(32'd300, 11'd2);
        test_random(470, 23, 23, 1);
        wait_drained();

        if (error_count == 0) begin
            $display("PASS gc_region_bump_allocator");
        end else begin
            $display("FAIL gc_region_bump_allocator");
        end
        $finish;
    end

endmodule
